// ===== rtl/adq_pkg.sv =====
`default_nettype none

package adq_pkg;

   // Field and register widths.
   localparam int SAMPLE_W    = 16;
   localparam int CODE_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam int GAIN_W      = 15;
   localparam int LEAK_W      = 16;
   localparam int WLEN_W      = 7;
   localparam int CLIP_W      = 15;

   // Register indexes on the write port.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_GAIN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAK_COEFF    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_MAX      = 2'd3;

   // Register reset values.
   localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd32767;
   localparam logic [LEAK_W-1:0] LEAK_RESET = 16'd0;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
   localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd7;

   // Shared divider: two quotient bits per cycle.
   localparam int DVD_W = 32;
   localparam int DVS_W = 16;
   localparam int CNT_W = 4;
   // Iteration counts minus one: 18 quotient bits for the code, 32 for the step.
   localparam logic [CNT_W-1:0] CNT_CODE = 4'd8;
   localparam logic [CNT_W-1:0] CNT_STEP = 4'd15;

   // Multiplier operand widths.
   localparam int MA_W  = 33;
   localparam int MB_W  = 16;
   localparam int MUL_W = MA_W + MB_W;

   // Rounding bias for a Q15 divide that truncates toward zero.
   localparam logic [32:0] Q15_BIAS = 33'd32767;

endpackage

`default_nettype wire

// ===== rtl/adaptive_differential_quantizer_top.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// req       in         req_valid/ready     req_sample      (16-bit signed)
// rsp       out        rsp_valid/ready     rsp_quant_code  (16-bit signed)
// csr       in         csr_we              csr_index, csr_wdata (no read-back)
//
// After acceptance, a word goes through the shared divider for the quantizer
// code (two quotient bits per cycle), then clipping, multiplies, window
// bookkeeping and prediction, and the same divider again for the step update
// before the next ready. The input is ready only while the sequencer is idle.
// The code goes into an output register as soon as it is clipped; if the
// previous code has not been taken yet, the sequencer waits there. The
// synchronous reset restores the control, state and configuration registers
// and marks every window entry empty, so no clearing pass is needed.

module adaptive_differential_quantizer_top #(
   parameter int MAX_WINDOW = 64
) (
   input  wire                                clock,
   input  wire                                reset,

   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  signed [adq_pkg::SAMPLE_W-1:0] req_sample,

   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [adq_pkg::CODE_W-1:0]  rsp_quant_code,

   input  wire                                csr_we,
   input  wire  [adq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [adq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIVQ = 4'd1;
   localparam logic [3:0] S_CLIP = 4'd2;
   localparam logic [3:0] S_MUL  = 4'd3;
   localparam logic [3:0] S_ACC  = 4'd4;
   localparam logic [3:0] S_PRED = 4'd5;
   localparam logic [3:0] S_GAIN = 4'd6;
   localparam logic [3:0] S_DIVS = 4'd7;
   localparam logic [3:0] S_STEP = 4'd8;

   // Configuration registers.
   logic [adq_pkg::GAIN_W-1:0]        gain_ff;
   logic signed [adq_pkg::LEAK_W-1:0] leak_ff;
   logic [adq_pkg::WLEN_W-1:0]        wlen_ff;
   logic [adq_pkg::CLIP_W-1:0]        clip_ff;

   // Quantizer state.
   logic [3:0]         state_ff, state_in;
   logic signed [15:0] step_ff, step_in;
   logic signed [15:0] pred_ff, pred_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] recon_ff, recon_in;
   logic [31:0]        sum_ff, sum_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               negq_ff, negq_in;
   logic signed [15:0] q_ff, q_in;

   // Shared divider.
   logic [adq_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [adq_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [adq_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [adq_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // Shared multiplier.
   logic signed [adq_pkg::MA_W-1:0]  mul_a;
   logic signed [adq_pkg::MB_W-1:0]  mul_b;
   logic signed [adq_pkg::MUL_W-1:0] mul_ff, mul_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]         code_ff, code_in;

   // Window store with one valid bit per entry; an empty entry reads as zero.
   logic [15:0]           win_mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] wvalid_ff;
   logic [15:0]           rd_ff;
   logic                  rd_valid_ff;

   // Combinational helpers.
   logic [LEN_W-1:0]   len_eff;
   logic [PTR_W-1:0]   ptr_eff;
   logic [LEN_W-1:0]   ptr_next;
   logic signed [16:0] diff;
   logic [16:0]        diff_abs;
   logic [15:0]        step_abs;
   logic               accept;
   logic               code_load;
   logic               win_write;
   logic [16:0]        t1, t2;
   logic               ge1, ge2;
   logic [15:0]        r1;
   logic signed [18:0] q_full;
   logic signed [18:0] clip_hi;
   logic signed [18:0] clip_lo;
   logic signed [31:0] deq;
   logic [31:0]        mag;
   logic [15:0]        old_mag;
   logic signed [32:0] leak_biased;
   logic [15:0]        leak_term;
   logic [15:0]        new_step;

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quant_code = code_ff;
   assign accept         = req_valid && req_ready;

   // Effective window length: zero behaves as one, anything above the store
   // depth behaves as the depth.
   always_comb begin
      if (wlen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if ({25'd0, wlen_ff} > 32'(MAX_WINDOW)) begin
         len_eff = LEN_W'(MAX_WINDOW);
      end else begin
         len_eff = LEN_W'(wlen_ff);
      end
   end

   // A pointer left beyond a shortened window restarts at entry zero.
   assign ptr_eff  = (LEN_W'(ptr_ff) >= len_eff) ? '0 : ptr_ff;
   assign ptr_next = LEN_W'(ptr_ff) + LEN_W'(1);

   assign diff     = 17'(req_sample) - 17'(pred_ff);
   assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
   assign step_abs = step_ff[15] ? 16'(-step_ff) : 16'(step_ff);

   // Divider core: two restoring steps per cycle on unsigned magnitudes.
   always_comb begin
      t1  = {rem_ff, dvd_ff[31]};
      ge1 = (t1 >= {1'b0, dvs_ff});
      r1  = ge1 ? 16'(t1 - {1'b0, dvs_ff}) : t1[15:0];
      t2  = {r1, dvd_ff[30]};
      ge2 = (t2 >= {1'b0, dvs_ff});
   end

   // Signed quotient and clip to the code range.
   assign q_full  = negq_ff ? -$signed({1'b0, dvd_ff[17:0]}) : $signed({1'b0, dvd_ff[17:0]});
   assign clip_hi = $signed({4'd0, clip_ff});
   assign clip_lo = ~clip_hi;

   // Dequantized difference and its magnitude come from the multiplier output.
   assign deq = mul_ff[31:0];
   assign mag = deq[31] ? 32'(-deq) : 32'(deq);
   assign old_mag = rd_valid_ff ? rd_ff : 16'd0;

   // Leak term divided by 32768, truncating toward zero.
   assign leak_biased = 33'(deq) + (deq[31] ? $signed(adq_pkg::Q15_BIAS) : 33'sd0);
   assign leak_term   = leak_biased[30:15];

   assign new_step = dvd_ff[15:0];

   // Multiplier operand selection by step of the sequence.
   always_comb begin
      case (state_ff)
         S_MUL: begin
            mul_a = adq_pkg::MA_W'(q_ff);
            mul_b = step_ff;
         end
         S_ACC: begin
            mul_a = adq_pkg::MA_W'(prev_ff);
            mul_b = leak_ff;
         end
         default: begin
            mul_a = $signed({1'b0, sum_ff});
            mul_b = $signed({1'b0, gain_ff});
         end
      endcase
   end

   assign mul_in = mul_a * mul_b;

   assign code_load = (state_ff == S_CLIP) && (!rsp_valid_ff || rsp_ready);
   assign win_write = (state_ff == S_ACC);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pred_in      = pred_ff;
      prev_in      = prev_ff;
      recon_in     = recon_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      negq_in      = negq_ff;
      q_in         = q_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ptr_in   = ptr_eff;
               negq_in  = diff[16] ^ step_ff[15];
               dvd_in   = {1'b0, diff_abs, 14'd0};
               dvs_in   = step_abs;
               rem_in   = '0;
               cnt_in   = adq_pkg::CNT_CODE;
               state_in = S_DIVQ;
            end
         end
         S_DIVQ, S_DIVS: begin
            dvd_in = {dvd_ff[29:0], ge1, ge2};
            rem_in = ge2 ? 16'(t2 - {1'b0, dvs_ff}) : t2[15:0];
            cnt_in = cnt_ff - adq_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = (state_ff == S_DIVQ) ? S_CLIP : S_STEP;
            end
         end
         S_CLIP: begin
            if (q_full > clip_hi) begin
               q_in = 16'(clip_hi);
            end else if (q_full < clip_lo) begin
               q_in = 16'(clip_lo);
            end else begin
               q_in = 16'(q_full);
            end
            if (code_load) begin
               code_in      = q_in;
               rsp_valid_in = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            recon_in = deq[15:0] + pred_ff;
            sum_in   = sum_ff - {16'd0, old_mag} + mag;
            state_in = S_PRED;
         end
         S_PRED: begin
            pred_in  = recon_ff - leak_term;
            prev_in  = recon_ff;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            // Shift by 15 first; the nested floor gives the same quotient.
            dvd_in   = mul_ff[46:15];
            dvs_in   = adq_pkg::DVS_W'(len_eff);
            rem_in   = '0;
            cnt_in   = adq_pkg::CNT_STEP;
            state_in = S_DIVS;
         end
         S_STEP: begin
            step_in  = (new_step == '0) ? 16'sd1 : new_step;
            ptr_in   = (ptr_next >= len_eff) ? '0 : PTR_W'(ptr_next);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 16'sd1;
         pred_ff      <= '0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wvalid_ff    <= '0;
         gain_ff      <= adq_pkg::GAIN_RESET;
         leak_ff      <= adq_pkg::LEAK_RESET;
         wlen_ff      <= adq_pkg::WLEN_RESET;
         clip_ff      <= adq_pkg::CLIP_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pred_ff      <= pred_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (win_write) begin
            wvalid_ff[ptr_ff] <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               adq_pkg::CSR_STEP_GAIN:     gain_ff <= csr_wdata[adq_pkg::GAIN_W-1:0];
               adq_pkg::CSR_LEAK_COEFF:    leak_ff <= csr_wdata;
               adq_pkg::CSR_WINDOW_LENGTH: wlen_ff <= csr_wdata[adq_pkg::WLEN_W-1:0];
               adq_pkg::CSR_CLIP_MAX:      clip_ff <= csr_wdata[adq_pkg::CLIP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      recon_ff <= recon_in;
      negq_ff  <= negq_in;
      q_ff     <= q_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      code_ff  <= code_in;
      mul_ff   <= mul_in;
   end

   // Window store: the old entry is read when a word is accepted and
   // replaced with the new magnitude in the accumulate step.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff       <= win_mem[ptr_eff];
         rd_valid_ff <= wvalid_ff[ptr_eff];
      end
      if (win_write) begin
         win_mem[ptr_ff] <= mag[15:0];
      end
   end

endmodule

`default_nettype wire
